[hw/rtl/bbl_pkg.sv]
// ----------------------------------------------------------------------------
// bbl_pkg: shared constants for the byte budget ledger
// Field widths, request modes, status codes and register indexes.
// ----------------------------------------------------------------------------
package bbl_pkg;

   // Default number of categories held in the ledger memory
   localparam int CATEGORY_COUNT_DEFAULT = 8;

   // Field widths
   localparam int MODE_W     = 3;
   localparam int CATEGORY_W = 4;
   localparam int BYTES_W    = 64;
   localparam int COUNT_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int SLICE_CAT_W = 3;
   localparam int CSR_INDEX_W = 1;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_SET           = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CHARGE        = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SLICE_CHARGE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SLICE_RELEASE = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CATEGORY   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_CAP_EXCEEDED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RELEASE_UNDER  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_SLICE_UNDER    = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_SLICE_OVER     = 3'd6;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAP_BYTES      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_CATEGORY = 1'd1;

endpackage

[hw/rtl/bbl_req_if.sv]
// ----------------------------------------------------------------------------
// bbl_req_if: request channel
// Valid/ready channel carrying one ledger request item.
// ----------------------------------------------------------------------------
interface bbl_req_if;

   logic                              valid;
   logic                              ready;
   logic [bbl_pkg::MODE_W-1:0]        mode;
   logic [bbl_pkg::CATEGORY_W-1:0]    category;
   logic [bbl_pkg::BYTES_W-1:0]       amount;

   modport source (output valid, output mode, output category, output amount,
                   input ready);
   modport sink   (input valid, input mode, input category, input amount,
                   output ready);

endinterface

[hw/rtl/bbl_rsp_if.sv]
// ----------------------------------------------------------------------------
// bbl_rsp_if: response channel
// Valid/ready channel carrying one ledger result item.
// ----------------------------------------------------------------------------
interface bbl_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [bbl_pkg::STATUS_W-1:0]    status;
   logic [bbl_pkg::BYTES_W-1:0]     category_total;
   logic [bbl_pkg::BYTES_W-1:0]     ledger_sum;
   logic [bbl_pkg::BYTES_W-1:0]     peak_total;
   logic [bbl_pkg::COUNT_W-1:0]     live_slices;
   logic [bbl_pkg::COUNT_W-1:0]     peak_live_slices;
   logic [bbl_pkg::BYTES_W-1:0]     slice_bytes;
   logic [bbl_pkg::BYTES_W-1:0]     peak_slice_bytes;

   modport source (output valid, output status, output category_total,
                   output ledger_sum, output peak_total, output live_slices,
                   output peak_live_slices, output slice_bytes,
                   output peak_slice_bytes, input ready);
   modport sink   (input valid, input status, input category_total,
                   input ledger_sum, input peak_total, input live_slices,
                   input peak_live_slices, input slice_bytes,
                   input peak_slice_bytes, output ready);

endinterface

[hw/rtl/byte_budget_ledger_top.sv]
// Each request item goes through the read, check and write passes over the category memory
// (one read port, one write port); the write pass holds until the output register is free.
// A new item is accepted only in idle, after the write pass of the last one is done.
// The next item is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) zeroes all totals, counts and peaks, sets the cap
// to all ones and the slice category to 0; category bytes read as zero until written.
// ----------------------------------------------------------------------------
// byte_budget_ledger_top: per-category byte ledger with total and slice tracking
// Category byte counts live in a small RAM; each item is read, checked against overflow,
// underflow and the cap, and written back only when it passes, with totals and peaks kept in flops.
// ----------------------------------------------------------------------------
module byte_budget_ledger_top #(
   parameter int CATEGORY_COUNT = bbl_pkg::CATEGORY_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   bbl_req_if.sink                             req_chan,
   bbl_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [bbl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bbl_pkg::BYTES_W-1:0]         csr_wdata
);

   localparam int IdxW = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
   localparam int BW   = bbl_pkg::BYTES_W;
   localparam int CW   = bbl_pkg::COUNT_W;
   localparam int SW   = bbl_pkg::STATUS_W;
   localparam int MW   = bbl_pkg::MODE_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_WRITE
   } state_type;

   state_type                      state_ff;

   // Configuration
   logic [BW-1:0]                  cap_ff;
   logic [bbl_pkg::SLICE_CAT_W-1:0] slice_cat_ff;

   // Item in flight
   logic [MW-1:0]                  mode_ff;
   logic                           addr_ok_ff;
   logic [IdxW-1:0]                idx_ff;
   logic [BW-1:0]                  amount_ff;
   logic [BW-1:0]                  cur_ff;
   logic [BW-1:0]                  val_ff;
   logic [BW-1:0]                  rest_ff;
   logic [BW-1:0]                  nt_ff;
   logic [SW-1:0]                  st_ff;

   // Ledger state outside the memory
   logic [CATEGORY_COUNT-1:0]      ent_vld_ff;
   logic [BW-1:0]                  total_ff;
   logic [BW-1:0]                  peak_ff;
   logic [CW-1:0]                  cnt_ff;
   logic [CW-1:0]                  peak_cnt_ff;
   logic [BW-1:0]                  mirror_ff;
   logic [BW-1:0]                  peak_mirror_ff;

   // Output register
   logic                           rsp_valid_ff;
   logic [SW-1:0]                  rsp_status_ff;
   logic [BW-1:0]                  rsp_cat_total_ff;

   // Combinational values
   logic                           req_fire;
   logic                           is_slice;
   logic [4:0]                     addr_wide;
   logic                           addr_ok_in;
   logic [IdxW-1:0]                idx_in;
   logic [BW-1:0]                  ram_rdata;
   logic [BW-1:0]                  cur_in;
   logic [BW:0]                    sum_in;
   logic [BW:0]                    diff_in;
   logic [BW-1:0]                  val_in;
   logic [SW-1:0]                  st1_in;
   logic [BW-1:0]                  rest_in;
   logic [BW:0]                    nt_sum;
   logic [SW-1:0]                  st2_in;
   logic                           out_free;
   logic                           wr_go;
   logic                           is_charge;
   logic                           is_release;
   logic [SW-1:0]                  fin_st;
   logic                           commit;
   logic                           slice_dec;
   logic [BW-1:0]                  total_in;
   logic [BW-1:0]                  peak_in;
   logic [CW-1:0]                  cnt_in;
   logic [CW-1:0]                  peak_cnt_in;
   logic [BW-1:0]                  mirror_in;
   logic [BW-1:0]                  peak_mirror_in;
   logic [BW-1:0]                  cat_total_in;

   // Address decode at acceptance
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign is_slice  = (req_chan.mode == bbl_pkg::MODE_SLICE_CHARGE) ||
                      (req_chan.mode == bbl_pkg::MODE_SLICE_RELEASE);
   assign addr_wide = is_slice ? {2'b00, slice_cat_ff} : {1'b0, req_chan.category};
   assign addr_ok_in = (addr_wide < 5'(CATEGORY_COUNT)) &&
                       (req_chan.mode <= bbl_pkg::MODE_SLICE_RELEASE);
   assign idx_in    = addr_ok_in ? addr_wide[IdxW-1:0] : '0;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Category memory: read at acceptance, write back on commit
   bbl_ram #(
      .WIDTH (BW),
      .DEPTH (CATEGORY_COUNT)
   ) u_cat_ram (
      .clock (clock),
      .we    (commit),
      .waddr (idx_ff),
      .wdata (val_ff),
      .re    (req_fire),
      .raddr (idx_in),
      .rdata (ram_rdata)
   );

   // Read pass: form the new category value and the total without it
   assign is_charge  = (mode_ff == bbl_pkg::MODE_CHARGE) ||
                       (mode_ff == bbl_pkg::MODE_SLICE_CHARGE);
   assign is_release = (mode_ff == bbl_pkg::MODE_RELEASE) ||
                       (mode_ff == bbl_pkg::MODE_SLICE_RELEASE);
   assign cur_in  = ent_vld_ff[idx_ff] ? ram_rdata : '0;
   assign sum_in  = {1'b0, cur_in} + {1'b0, amount_ff};
   assign diff_in = {1'b0, cur_in} - {1'b0, amount_ff};
   assign rest_in = total_ff - cur_in;

   always_comb begin
      priority if (is_charge) begin
         val_in = sum_in[BW-1:0];
         st1_in = sum_in[BW] ? bbl_pkg::STATUS_OVERFLOW : bbl_pkg::STATUS_OK;
      end else if (is_release) begin
         val_in = diff_in[BW-1:0];
         st1_in = diff_in[BW] ? bbl_pkg::STATUS_RELEASE_UNDER : bbl_pkg::STATUS_OK;
      end else begin
         val_in = amount_ff;
         st1_in = bbl_pkg::STATUS_OK;
      end
   end

   // Check pass: new total against 64 bits and the cap
   assign nt_sum = {1'b0, rest_ff} + {1'b0, val_ff};

   always_comb begin
      priority if (st_ff != bbl_pkg::STATUS_OK) begin
         st2_in = st_ff;
      end else if (nt_sum[BW]) begin
         st2_in = bbl_pkg::STATUS_OVERFLOW;
      end else if (nt_sum[BW-1:0] > cap_ff) begin
         st2_in = bbl_pkg::STATUS_CAP_EXCEEDED;
      end else begin
         st2_in = bbl_pkg::STATUS_OK;
      end
   end

   // Write pass: settle status, slice count rules and the new ledger state
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign wr_go    = (state_ff == ST_WRITE) && out_free;

   always_comb begin
      priority if ((mode_ff == bbl_pkg::MODE_SLICE_RELEASE) && (cnt_ff == '0)) begin
         fin_st = bbl_pkg::STATUS_SLICE_UNDER;
      end else if (!addr_ok_ff) begin
         fin_st = bbl_pkg::STATUS_BAD_CATEGORY;
      end else if ((mode_ff == bbl_pkg::MODE_SLICE_CHARGE) &&
                   (st_ff == bbl_pkg::STATUS_OK) && (&cnt_ff)) begin
         fin_st = bbl_pkg::STATUS_SLICE_OVER;
      end else begin
         fin_st = st_ff;
      end
   end

   assign commit    = wr_go && (fin_st == bbl_pkg::STATUS_OK);
   assign slice_dec = wr_go && (mode_ff == bbl_pkg::MODE_SLICE_RELEASE) && (cnt_ff != '0);

   always_comb begin
      total_in       = commit ? nt_ff : total_ff;
      peak_in        = (commit && (nt_ff > peak_ff)) ? nt_ff : peak_ff;
      priority if (commit && (mode_ff == bbl_pkg::MODE_SLICE_CHARGE)) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (slice_dec) begin
         cnt_in = cnt_ff - CW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      peak_cnt_in    = (cnt_in > peak_cnt_ff) ? cnt_in : peak_cnt_ff;
      mirror_in      = (commit && ((mode_ff == bbl_pkg::MODE_SLICE_CHARGE) ||
                                   (mode_ff == bbl_pkg::MODE_SLICE_RELEASE)))
                       ? val_ff : mirror_ff;
      peak_mirror_in = (commit && (mode_ff == bbl_pkg::MODE_SLICE_CHARGE) &&
                        (val_ff > peak_mirror_ff)) ? val_ff : peak_mirror_ff;
      cat_total_in   = !addr_ok_ff ? '0 : (commit ? val_ff : cur_ff);
   end

   // Sequencer, ledger state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cap_ff         <= '1;
         slice_cat_ff   <= '0;
         ent_vld_ff     <= '0;
         total_ff       <= '0;
         peak_ff        <= '0;
         cnt_ff         <= '0;
         peak_cnt_ff    <= '0;
         mirror_ff      <= '0;
         peak_mirror_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Configuration writes
         if (csr_we) begin
            unique case (csr_index)
               bbl_pkg::CSR_CAP_BYTES: begin
                  cap_ff <= csr_wdata;
               end
               bbl_pkg::CSR_SLICE_CATEGORY: begin
                  slice_cat_ff <= csr_wdata[bbl_pkg::SLICE_CAT_W-1:0];
               end
               default: begin
                  cap_ff <= cap_ff;
               end
            endcase
         end

         // Drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_chan.ready && !wr_go) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               // Hold until the output register is free
               if (out_free) begin
                  state_ff       <= ST_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  total_ff       <= total_in;
                  peak_ff        <= peak_in;
                  cnt_ff         <= cnt_in;
                  peak_cnt_ff    <= peak_cnt_in;
                  mirror_ff      <= mirror_in;
                  peak_mirror_ff <= peak_mirror_in;
                  if (commit) begin
                     ent_vld_ff[idx_ff] <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= req_chan.mode;
         addr_ok_ff <= addr_ok_in;
         idx_ff     <= idx_in;
         amount_ff  <= req_chan.amount;
      end
      if (state_ff == ST_READ) begin
         cur_ff  <= cur_in;
         val_ff  <= val_in;
         rest_ff <= rest_in;
         st_ff   <= st1_in;
      end
      if (state_ff == ST_CHECK) begin
         nt_ff <= nt_sum[BW-1:0];
         st_ff <= st2_in;
      end
      if (wr_go) begin
         rsp_status_ff    <= fin_st;
         rsp_cat_total_ff <= cat_total_in;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.category_total   = rsp_cat_total_ff;
   assign rsp_chan.ledger_sum       = total_ff;
   assign rsp_chan.peak_total       = peak_ff;
   assign rsp_chan.live_slices      = cnt_ff;
   assign rsp_chan.peak_live_slices = peak_cnt_ff;
   assign rsp_chan.slice_bytes      = mirror_ff;
   assign rsp_chan.peak_slice_bytes = peak_mirror_ff;

`ifndef NO_ASSERTIONS
   // Peak total never falls below the running total
   a_peak_total: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= total_ff)
      else $error("peak total below running total");

   // Peak slice count never falls below the live count
   a_peak_cnt: assert property (@(posedge clock) disable iff (reset)
      peak_cnt_ff >= cnt_ff)
      else $error("peak live slices below live slices");

   // Live slice count moves by at most one per item
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(cnt_ff) |-> (cnt_ff == $past(cnt_ff) + CW'(1)) ||
                           (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("live slice count jumped");

   // A result appears only out of the write pass
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result raised outside write pass");

   // Memory is written only on a successful commit of a valid category
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      commit |-> addr_ok_ff && (state_ff == ST_WRITE))
      else $error("memory write without valid commit");
`endif

endmodule

[hw/rtl/bbl_ram.sv]
// ----------------------------------------------------------------------------
// bbl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module bbl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AddrW-1:0]  waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [AddrW-1:0]  raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[tb/sv/bbl_ledger_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbl_ledger_checker: result predictor and scoreboard for the byte ledger
// Watches the request, result and register ports. Keeps its own copy of the
// ledger, works out the result of every accepted request item, and compares
// each accepted result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bbl_ledger_checker
   import bbl_pkg::*;
#(
   parameter int CATEGORY_COUNT = CATEGORY_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   bbl_req_if                     req_mon,
   bbl_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTES_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     pending_results
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTES_W-1:0]  category_total;
      logic [BYTES_W-1:0]  ledger_sum;
      logic [BYTES_W-1:0]  peak_total;
      logic [COUNT_W-1:0]  live_slices;
      logic [COUNT_W-1:0]  peak_live_slices;
      logic [BYTES_W-1:0]  slice_bytes;
      logic [BYTES_W-1:0]  peak_slice_bytes;
   } ledger_result_type;

   // Register copies
   logic [BYTES_W-1:0]     cap_limit;
   logic [SLICE_CAT_W-1:0] slice_cat;

   // Ledger copy
   logic [BYTES_W-1:0] cat_bytes [CATEGORY_COUNT];
   logic [BYTES_W-1:0] ledger_total;
   logic [BYTES_W-1:0] ledger_peak;
   logic [COUNT_W-1:0] live_count;
   logic [COUNT_W-1:0] live_peak;
   logic [BYTES_W-1:0] mirror_bytes;
   logic [BYTES_W-1:0] mirror_peak;

   ledger_result_type expected_results [$];
   int                error_tally = 0;

   // New byte count of one category for a set, charge or release
   function automatic logic [STATUS_W-1:0] next_bytes(input logic [MODE_W-1:0] op,
         input logic [BYTES_W-1:0] held, input logic [BYTES_W-1:0] amount,
         output logic [BYTES_W-1:0] value);
      value = amount;
      if (op == MODE_CHARGE) begin
         if (amount > ~held) return STATUS_OVERFLOW;
         value = held + amount;
      end else if (op == MODE_RELEASE) begin
         if (amount > held) return STATUS_RELEASE_UNDER;
         value = held - amount;
      end
      return STATUS_OK;
   endfunction

   // Total after replacing one category; overflow is checked ahead of the cap
   function automatic logic [STATUS_W-1:0] fit_total(input int idx,
         input logic [BYTES_W-1:0] value, output logic [BYTES_W-1:0] new_total);
      logic [BYTES_W-1:0] rest;
      rest      = ledger_total - cat_bytes[idx];
      new_total = rest + value;
      if (value > ~rest) return STATUS_OVERFLOW;
      if (new_total > cap_limit) return STATUS_CAP_EXCEEDED;
      return STATUS_OK;
   endfunction

   function automatic void commit_bytes(input int idx, input logic [BYTES_W-1:0] value,
         input logic [BYTES_W-1:0] new_total);
      cat_bytes[idx] = value;
      ledger_total   = new_total;
      if (new_total > ledger_peak) ledger_peak = new_total;
   endfunction

   // Apply one request item to the ledger copy and return its result item
   function automatic ledger_result_type apply_request(input logic [MODE_W-1:0] mode,
         input logic [CATEGORY_W-1:0] category, input logic [BYTES_W-1:0] amount);
      ledger_result_type     r;
      logic                  slice_op;
      logic                  addr_ok;
      logic [CATEGORY_W-1:0] addr;
      int                    idx;
      logic [STATUS_W-1:0]   status;
      logic [BYTES_W-1:0]    value;
      logic [BYTES_W-1:0]    new_total;
      slice_op  = (mode == MODE_SLICE_CHARGE) || (mode == MODE_SLICE_RELEASE);
      addr      = slice_op ? CATEGORY_W'(slice_cat) : category;
      addr_ok   = (int'(addr) < CATEGORY_COUNT) && (mode <= MODE_SLICE_RELEASE);
      idx       = addr_ok ? int'(addr) : 0;
      value     = '0;
      new_total = '0;
      if (!addr_ok) begin
         // Bad category or mode; a slice release still takes its slice
         if (mode == MODE_SLICE_RELEASE && live_count == '0) begin
            status = STATUS_SLICE_UNDER;
         end else begin
            status = STATUS_BAD_CATEGORY;
            if (mode == MODE_SLICE_RELEASE) live_count = live_count - COUNT_W'(1);
         end
      end else if (!slice_op) begin
         status = next_bytes(mode, cat_bytes[idx], amount, value);
         if (status == STATUS_OK) status = fit_total(idx, value, new_total);
         if (status == STATUS_OK) commit_bytes(idx, value, new_total);
      end else if (mode == MODE_SLICE_CHARGE) begin
         status = next_bytes(MODE_CHARGE, cat_bytes[idx], amount, value);
         if (status == STATUS_OK) status = fit_total(idx, value, new_total);
         if (status == STATUS_OK && live_count == '1) status = STATUS_SLICE_OVER;
         if (status == STATUS_OK) begin
            commit_bytes(idx, value, new_total);
            live_count = live_count + COUNT_W'(1);
            if (live_count > live_peak) live_peak = live_count;
            mirror_bytes = cat_bytes[idx];
            if (mirror_bytes > mirror_peak) mirror_peak = mirror_bytes;
         end
      end else if (live_count == '0) begin
         status = STATUS_SLICE_UNDER;
      end else begin
         // Slice is dropped even when the release itself fails
         live_count = live_count - COUNT_W'(1);
         status = next_bytes(MODE_RELEASE, cat_bytes[idx], amount, value);
         if (status == STATUS_OK) status = fit_total(idx, value, new_total);
         if (status == STATUS_OK) begin
            commit_bytes(idx, value, new_total);
            mirror_bytes = cat_bytes[idx];
         end
      end
      r.status           = status;
      r.category_total   = addr_ok ? cat_bytes[idx] : '0;
      r.ledger_sum       = ledger_total;
      r.peak_total       = ledger_peak;
      r.live_slices      = live_count;
      r.peak_live_slices = live_peak;
      r.slice_bytes      = mirror_bytes;
      r.peak_slice_bytes = mirror_peak;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [BYTES_W-1:0] want,
         input logic [BYTES_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
         error_tally++;
      end
   endtask

   // Track registers, predict on request accept, compare on result accept
   always @(posedge clock) begin
      ledger_result_type want;
      if (reset) begin
         cap_limit    = '1;
         slice_cat    = '0;
         for (int i = 0; i < CATEGORY_COUNT; i++) cat_bytes[i] = '0;
         ledger_total = '0;
         ledger_peak  = '0;
         live_count   = '0;
         live_peak    = '0;
         mirror_bytes = '0;
         mirror_peak  = '0;
         expected_results.delete();
      end else begin
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_CAP_BYTES:      cap_limit = csr_wdata;
               CSR_SLICE_CATEGORY: slice_cat = csr_wdata[SLICE_CAT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            expected_results.insert(expected_results.size(),
                                    apply_request(req_mon.mode, req_mon.category,
                                                  req_mon.amount));
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result item with none expected, status %0h", $time,
                        rsp_mon.status);
               error_tally++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", BYTES_W'(want.status), BYTES_W'(rsp_mon.status));
               check_field("category_total", want.category_total, rsp_mon.category_total);
               check_field("ledger_sum", want.ledger_sum, rsp_mon.ledger_sum);
               check_field("peak_total", want.peak_total, rsp_mon.peak_total);
               check_field("live_slices", BYTES_W'(want.live_slices),
                           BYTES_W'(rsp_mon.live_slices));
               check_field("peak_live_slices", BYTES_W'(want.peak_live_slices),
                           BYTES_W'(rsp_mon.peak_live_slices));
               check_field("slice_bytes", want.slice_bytes, rsp_mon.slice_bytes);
               check_field("peak_slice_bytes", want.peak_slice_bytes,
                           rsp_mon.peak_slice_bytes);
            end
         end
      end
      fail_count      <= error_tally;
      pending_results <= expected_results.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: byte budget ledger testbench
// Drives directed and random ledger requests through several cap and slice
// category settings and idle patterns, including a long result hold-off that
// fills the block; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
   import bbl_pkg::*;

   localparam int ITEM_COUNT     = 950;
   localparam int PHASE_COUNT    = 5;
   localparam int SETTLE_CYCLES  = 6;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTES_W-1:0]     csr_wdata;
   int                     fail_count;
   int                     pending_results;
   int                     idle_pct = 0;
   int                     stall_pct = 0;
   int                     holdoff_asked = 0;

   bbl_req_if req_chan ();
   bbl_rsp_if rsp_chan ();

   byte_budget_ledger_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bbl_ledger_checker ledger_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random stalls, plus a long hold-off when one is asked for
   initial begin
      int holdoff_taken;
      int holdoff_left;
      holdoff_taken = 0;
      holdoff_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holdoff_taken != holdoff_asked) begin
            holdoff_taken = holdoff_asked;
            holdoff_left  = HOLDOFF_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Offer one request item, with an optional idle gap first; hold until taken
   task automatic send_request(input logic [MODE_W-1:0] mode,
         input logic [CATEGORY_W-1:0] category, input logic [BYTES_W-1:0] amount);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.category <= category;
      req_chan.amount   <= amount;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Stop offering, wait for every result, then let the pipeline settle
   task automatic drain_ledger();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_ledger(input logic [BYTES_W-1:0] cap,
         input logic [BYTES_W-1:0] slice_word);
      drain_ledger();
      csr_we    <= 1'b1;
      csr_index <= CSR_CAP_BYTES;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= CSR_SLICE_CATEGORY;
      csr_wdata <= slice_word;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly small amounts so charges and releases go through; some huge
   function automatic logic [BYTES_W-1:0] random_amount();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return BYTES_W'($urandom_range(0, 255));
      if (roll < 75) return BYTES_W'($urandom_range(0, 65535));
      if (roll < 85) return {$urandom, $urandom};
      if (roll < 93) return BYTES_MAX - BYTES_W'($urandom_range(0, 255));
      return '0;
   endfunction

   initial begin
      int                    phase;
      int                    n;
      int                    roll;
      logic [MODE_W-1:0]     mode;
      logic [CATEGORY_W-1:0] category;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.mode     <= MODE_SET;
      req_chan.category <= '0;
      req_chan.amount   <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_CAP_BYTES;
      csr_wdata         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: bad category and mode, overflow, release and slice underflow, slice bookkeeping
      configure_ledger(BYTES_MAX, BYTES_W'(0));
      send_request(MODE_SET, CATEGORY_W'(0), BYTES_W'(100));
      send_request(MODE_CHARGE, CATEGORY_W'(7), BYTES_W'(50));
      send_request(MODE_RELEASE, CATEGORY_W'(7), BYTES_W'(60));
      send_request(MODE_CHARGE, CATEGORY_W'(15), {$urandom, $urandom});
      send_request(MODE_SLICE_RELEASE + MODE_W'(1), CATEGORY_W'(1), BYTES_W'(7));
      send_request(MODE_SLICE_RELEASE + MODE_W'(2), CATEGORY_W'(2), BYTES_W'(7));
      send_request(MODE_SLICE_RELEASE + MODE_W'(3), CATEGORY_W'(3), BYTES_W'(7));
      send_request(MODE_SET, CATEGORY_W'(1), BYTES_MAX);
      send_request(MODE_CHARGE, CATEGORY_W'(0), BYTES_MAX - BYTES_W'(15));
      send_request(MODE_SLICE_RELEASE, CATEGORY_W'(0), BYTES_W'(5));
      send_request(MODE_SLICE_CHARGE, CATEGORY_W'(0), BYTES_W'(40));
      send_request(MODE_SLICE_CHARGE, CATEGORY_W'(0), BYTES_W'(0));
      send_request(MODE_SLICE_RELEASE, CATEGORY_W'(0), BYTES_W'(1000));
      send_request(MODE_SLICE_RELEASE, CATEGORY_W'(0), BYTES_W'(40));
      send_request(MODE_RELEASE, CATEGORY_W'(0), BYTES_W'(0));

      // Cap dropped below the total: even releases and sets are refused
      configure_ledger(BYTES_W'(0), BYTES_W'(7));
      send_request(MODE_RELEASE, CATEGORY_W'(0), BYTES_W'(10));
      send_request(MODE_SET, CATEGORY_W'(7), BYTES_W'(0));
      send_request(MODE_SLICE_CHARGE, CATEGORY_W'(0), BYTES_W'(0));
      send_request(MODE_SLICE_RELEASE, CATEGORY_W'(0), BYTES_W'(1));

      // Random phases, each with its own cap, slice category and idle pattern
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
               configure_ledger(BYTES_W'(20000), BYTES_W'(0));
            end
            1: begin
               idle_pct = 48;
               stall_pct <= 0;
               configure_ledger(BYTES_W'($urandom_range(1000, 60000)), BYTES_W'(7));
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 48;
               configure_ledger(BYTES_W'(1000000), {$urandom, $urandom});
            end
            3: begin
               idle_pct = 16;
               stall_pct <= 16;
               configure_ledger(BYTES_MAX, BYTES_W'(3));
            end
            default: begin
               idle_pct = 0;
               stall_pct <= 0;
               configure_ledger({$urandom, $urandom}, BYTES_W'(5));
               holdoff_asked <= holdoff_asked + 1;
            end
         endcase
         for (n = 0; n < ITEM_COUNT / PHASE_COUNT; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) mode = MODE_SET;
            else if (roll < 40) mode = MODE_CHARGE;
            else if (roll < 62) mode = MODE_RELEASE;
            else if (roll < 80) mode = MODE_SLICE_CHARGE;
            else if (roll < 95) mode = MODE_SLICE_RELEASE;
            else mode = MODE_SLICE_RELEASE + MODE_W'($urandom_range(1, 3));
            if ($urandom_range(0, 9) == 0)
               category = CATEGORY_W'($urandom_range(CATEGORY_COUNT_DEFAULT, 15));
            else
               category = CATEGORY_W'($urandom_range(0, CATEGORY_COUNT_DEFAULT - 1));
            send_request(mode, category, random_amount());
         end
      end

      // Closing: drive the total to the full 64-bit range, then overflow it
      idle_pct = 0;
      stall_pct <= 0;
      configure_ledger(BYTES_MAX, BYTES_W'(4));
      for (n = 0; n < CATEGORY_COUNT_DEFAULT; n++)
         send_request(MODE_SET, CATEGORY_W'(n), '0);
      send_request(MODE_SLICE_CHARGE, CATEGORY_W'(0), BYTES_MAX);
      send_request(MODE_CHARGE, CATEGORY_W'(5), BYTES_W'(1));
      send_request(MODE_SLICE_RELEASE, CATEGORY_W'(0), BYTES_MAX);

      drain_ledger();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
